FILE: sv/hddr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heater duty deadband regulator.
// No dependencies; every other file imports this package.
package hddr_pkg;

    localparam int NCH        = 3;
    localparam int CHANNELS   = 3;
    localparam int DECIMATION = 2;

    localparam int TEMP_W = 12;
    localparam int DUTY_W = 13;
    localparam int MASK_W = NCH;
    localparam int CFG_W  = 13;
    localparam int IDX_W  = 3;
    localparam int PHASE_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

    localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(5000);
    localparam logic [DUTY_W-1:0] DUTY_MIN = DUTY_W'(100);
    localparam logic [DUTY_W-1:0] DEADBAND = DUTY_W'(10);

    typedef enum logic [IDX_W-1:0] {
        REG_SETPOINT_CH0,
        REG_SETPOINT_CH1,
        REG_SETPOINT_CH2,
        REG_FEEDBACK_MASK,
        REG_INITIAL_DUTY
    } cfg_reg_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              upd;
        logic              hot;
        logic              cold;
    } lane_res_t;

    typedef struct packed {
        logic [NCH-1:0][DUTY_W-1:0] duty;
        logic [NCH-1:0]             upd;
        logic [NCH-1:0]             hot;
        logic [NCH-1:0]             cold;
    } out_rec_t;

endpackage

FILE: sv/hddr_if.sv
`timescale 1ns / 1ps
// Stream interfaces: ADC frame beats in, regulator result beats out.
// Depends on hddr_pkg.
interface hddr_frame_if;
    import hddr_pkg::*;

    logic              valid;
    logic              ready;
    logic [TEMP_W-1:0] temp_ch0;
    logic [TEMP_W-1:0] temp_ch1;
    logic [TEMP_W-1:0] temp_ch2;

    modport source (output valid, output temp_ch0, output temp_ch1, output temp_ch2,
                    input ready);
    modport sink   (input valid, input temp_ch0, input temp_ch1, input temp_ch2,
                    output ready);
endinterface

interface hddr_result_if;
    import hddr_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty_ch0;
    logic [DUTY_W-1:0] duty_ch1;
    logic [DUTY_W-1:0] duty_ch2;
    logic [MASK_W-1:0] update_mask;
    logic [MASK_W-1:0] overheat_clamp_mask;
    logic [MASK_W-1:0] undercool_clamp_mask;

    modport source (output valid, output duty_ch0, output duty_ch1, output duty_ch2,
                    output update_mask, output overheat_clamp_mask,
                    output undercool_clamp_mask, input ready);
    modport sink   (input valid, input duty_ch0, input duty_ch1, input duty_ch2,
                    input update_mask, input overheat_clamp_mask,
                    input undercool_clamp_mask, output ready);
endinterface

FILE: sv/hddr_lane.sv
`timescale 1ns / 1ps
// One regulation lane: holds a channel duty and steps it against the deadband.
// Depends on hddr_pkg.
module hddr_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [hddr_pkg::TEMP_W-1:0] temp,
    input  logic [hddr_pkg::TEMP_W-1:0] setpoint,
    input  logic                      enable,
    input  logic                      step,
    input  logic                      load,
    input  logic [hddr_pkg::DUTY_W-1:0] load_duty,
    output hddr_pkg::lane_res_t       res
);
    import hddr_pkg::*;

    logic [DUTY_W-1:0] duty_reg;
    logic [DUTY_W-1:0] duty_next;
    logic [DUTY_W-1:0] temp_x;
    logic [DUTY_W-1:0] set_x;
    logic              active;
    logic              too_cold;
    logic              too_warm;

    assign temp_x   = DUTY_W'(temp);
    assign set_x    = DUTY_W'(setpoint);
    assign active   = enable && (duty_reg != '0);
    assign too_cold = (temp_x + DEADBAND) < set_x;
    assign too_warm = temp_x > (set_x + DEADBAND);

    always_comb
    begin
        res.duty = duty_reg;
        res.upd  = 1'b0;
        res.hot  = 1'b0;
        res.cold = 1'b0;
        if (active && too_cold)
        begin
            res.upd = 1'b1;
            if (duty_reg >= DUTY_MAX)
            begin
                res.duty = DUTY_MAX;
                res.hot  = 1'b1;
            end
            else
            begin
                res.duty = duty_reg + DUTY_W'(1);
            end
        end
        else if (active && too_warm)
        begin
            res.upd = 1'b1;
            if (duty_reg <= DUTY_MIN)
            begin
                res.duty = DUTY_MIN;
                res.cold = 1'b1;
            end
            else
            begin
                res.duty = duty_reg - DUTY_W'(1);
            end
        end
    end

    always_comb
    begin
        duty_next = duty_reg;
        if (load)
        begin
            duty_next = load_duty;
        end
        else if (step)
        begin
            duty_next = res.duty;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0;
        end
        else
        begin
            duty_reg <= duty_next;
        end
    end

endmodule

FILE: sv/hddr_merge.sv
`timescale 1ns / 1ps
// Merge stage: gathers lane results into one beat, with output register and skid.
// Depends on hddr_pkg and hddr_result_if.
module hddr_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  hddr_pkg::lane_res_t  lane_res [hddr_pkg::NCH],
    output logic                 can_accept,
    hddr_result_if.source        result
);
    import hddr_pkg::*;

    out_rec_t rec;
    out_rec_t out_reg;
    out_rec_t out_next;
    out_rec_t skid_reg;
    out_rec_t skid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     skid_valid_reg;
    logic     skid_valid_next;
    logic     out_fire;

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            rec.duty[i] = lane_res[i].duty;
            rec.upd[i]  = lane_res[i].upd;
            rec.hot[i]  = lane_res[i].hot;
            rec.cold[i] = lane_res[i].cold;
        end
    end

    assign out_fire   = out_valid_reg && result.ready;
    assign can_accept = !skid_valid_reg;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = rec;
                skid_valid_next = push;
            end
            else
            begin
                out_next       = rec;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = rec;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign result.valid                = out_valid_reg;
    assign result.duty_ch0             = out_reg.duty[0];
    assign result.duty_ch1             = out_reg.duty[1];
    assign result.duty_ch2             = out_reg.duty[2];
    assign result.update_mask          = out_reg.upd;
    assign result.overheat_clamp_mask  = out_reg.hot;
    assign result.undercool_clamp_mask = out_reg.cold;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_clamp_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.hot & out_reg.cold) == '0))
        else $error("channel flagged at both clamp limits");

    a_clamp_updates: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((out_reg.hot | out_reg.cold) & ~out_reg.upd) == '0))
        else $error("clamp flag without duty update");

    a_duty_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.duty[0] <= DUTY_MAX && out_reg.duty[1] <= DUTY_MAX
                           && out_reg.duty[2] <= DUTY_MAX))
        else $error("reported duty above ceiling");

endmodule

FILE: sv/heater_duty_deadband_regulator.sv
`timescale 1ns / 1ps
// Top level of the heater duty deadband regulator: configuration, frame decimation, lanes.
// Depends on hddr_pkg, hddr_if, hddr_lane and hddr_merge.

// Accepts one ADC frame beat per clock while frame ready is high. Every second
// frame is acted on: each of the three channel lanes steps its duty in the same
// cycle the frame is taken, and the merged result beat is registered into the
// output register, or into the one-beat skid stage behind it while the output
// register is held. Frame ready only drops once both hold result beats; frames
// that are not acted on still need that slot free. Writing initial_duty loads
// the clamped value into every channel duty at once.
module heater_duty_deadband_regulator (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [hddr_pkg::IDX_W-1:0] cfg_index,
    input  logic [hddr_pkg::CFG_W-1:0] cfg_wdata,
    hddr_frame_if.sink                 frame,
    hddr_result_if.source              result
);
    import hddr_pkg::*;

    logic [TEMP_W-1:0]  setpoint_reg [NCH];
    logic [TEMP_W-1:0]  setpoint_next [NCH];
    logic [MASK_W-1:0]  fb_mask_reg;
    logic [MASK_W-1:0]  fb_mask_next;
    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic               load_init;
    logic [DUTY_W-1:0]  load_duty;
    logic               can_accept;
    logic               accept;
    logic               act;
    logic [TEMP_W-1:0]  temps [NCH];
    lane_res_t          lane_res [NCH];

    assign frame.ready = can_accept;
    assign accept      = frame.valid && can_accept;
    assign act         = (phase_reg == PHASE_W'(DECIMATION - 1));

    assign temps[0] = frame.temp_ch0;
    assign temps[1] = frame.temp_ch1;
    assign temps[2] = frame.temp_ch2;

    assign load_duty = (cfg_wdata > DUTY_MAX) ? DUTY_MAX : cfg_wdata;

    always_comb
    begin
        setpoint_next = setpoint_reg;
        fb_mask_next  = fb_mask_reg;
        load_init     = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SETPOINT_CH0:  setpoint_next[0] = cfg_wdata[TEMP_W-1:0];
                REG_SETPOINT_CH1:  setpoint_next[1] = cfg_wdata[TEMP_W-1:0];
                REG_SETPOINT_CH2:  setpoint_next[2] = cfg_wdata[TEMP_W-1:0];
                REG_FEEDBACK_MASK: fb_mask_next     = cfg_wdata[MASK_W-1:0];
                REG_INITIAL_DUTY:  load_init        = 1'b1;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            phase_next = act ? '0 : phase_reg + PHASE_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NCH; i++)
            begin
                setpoint_reg[i] <= '0;
            end
            fb_mask_reg <= '0;
            phase_reg   <= '0;
        end
        else
        begin
            setpoint_reg <= setpoint_next;
            fb_mask_reg  <= fb_mask_next;
            phase_reg    <= phase_next;
        end
    end

    for (genvar g = 0; g < NCH; g++)
    begin : g_lane
        hddr_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .temp      (temps[g]),
            .setpoint  (setpoint_reg[g]),
            .enable    ((g < CHANNELS) && fb_mask_reg[g]),
            .step      (accept && act),
            .load      (load_init),
            .load_duty (load_duty),
            .res       (lane_res[g])
        );
    end

    hddr_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept && act),
        .lane_res   (lane_res),
        .can_accept (can_accept),
        .result     (result)
    );

endmodule
